FILE: rtl/tsu_pkg.sv
// tsu_pkg: shared types, result kind codes and block id lists for the tdc subevent unpacker
// no dependencies
package tsu_pkg;

    // input transaction payload
    typedef struct packed {
        logic [31:0] word;
        logic        first_word;
    } tsu_in_t;

    // result transaction payload
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] tdc_id;
        logic [6:0]  channel;
        logic [1:0]  channel_class;
        logic        edge_res;
        logic [27:0] epoch;
        logic [10:0] coarse;
        logic [9:0]  fine;
        logic        size_error;
    } tsu_out_t;

    // classified word handed from the parser to the decoder
    typedef struct packed {
        logic [3:0]  kind;
        logic        decode;
        logic [15:0] tdc_id;
        logic [31:0] word;
        logic        size_error;
    } tsu_item_t;

    // result kinds
    localparam logic [3:0] KIND_SUBHDR   = 4'd0;
    localparam logic [3:0] KIND_BLKHDR   = 4'd1;
    localparam logic [3:0] KIND_HIT      = 4'd2;
    localparam logic [3:0] KIND_FAULTY   = 4'd3;
    localparam logic [3:0] KIND_EPOCH    = 4'd4;
    localparam logic [3:0] KIND_TDCHDR   = 4'd5;
    localparam logic [3:0] KIND_DEBUG    = 4'd6;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd7;
    localparam logic [3:0] KIND_SKIPPED  = 4'd8;
    localparam logic [3:0] KIND_STRAY    = 4'd9;

    // channel classes
    localparam logic [1:0] CLASS_SYNC     = 2'd0;
    localparam logic [1:0] CLASS_LEADING  = 2'd1;
    localparam logic [1:0] CLASS_TRAILING = 2'd2;

    // payload word types, bits 30..29 of a non-time word
    localparam logic [1:0] WTYPE_TDCHDR = 2'd1;
    localparam logic [1:0] WTYPE_DEBUG  = 2'd2;
    localparam logic [1:0] WTYPE_EPOCH  = 2'd3;

    localparam logic [9:0] FINE_FAULTY = 10'h3ff;

    // queue between parser and decoder
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    function automatic logic is_skip_id(input logic [15:0] id);
        return (id == 16'h7005) || (id == 16'h5555) || (id == 16'h0112) || (id == 16'hc000);
    endfunction

    function automatic logic is_hub_id(input logic [15:0] id);
        return (id == 16'h7000) || (id == 16'h7001) || (id == 16'h7002) || (id == 16'h7003);
    endfunction

endpackage

FILE: rtl/tsu_front.sv
// tsu_front: subevent parser, tracks header/block counters and classifies each word
// depends on tsu_pkg
module tsu_front import tsu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  tsu_in_t   in_data,
    output tsu_item_t item
);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_SUBHDR = 3'd1;
    localparam logic [2:0] MODE_TOPHDR = 3'd2;
    localparam logic [2:0] MODE_BLKHDR = 3'd3;
    localparam logic [2:0] MODE_HUBTDC = 3'd4;
    localparam logic [2:0] MODE_SKIP   = 3'd5;
    localparam logic [2:0] MODE_DATA   = 3'd6;

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [15:0] sub_left_reg, sub_left_next;
    logic [15:0] top_left_reg, top_left_next;
    logic [15:0] tdc_left_reg, tdc_left_next;
    logic [15:0] cur_tdc_reg, cur_tdc_next;

    logic [29:0] size_words;
    logic [15:0] size_sat;
    logic        size_over;
    logic [15:0] blk_cnt;
    logic [15:0] blk_id;
    logic        take_hdr;

    assign blk_cnt    = in_data.word[31:16];
    assign blk_id     = in_data.word[15:0];
    assign size_words = in_data.word[31:2];
    assign size_over  = |size_words[29:16];
    assign size_sat   = size_over ? 16'hffff : size_words[15:0];

    // next state and classification of the word on the input
    always_comb begin
        mode_next     = mode_reg;
        hdr_idx_next  = hdr_idx_reg;
        sub_left_next = sub_left_reg;
        top_left_next = top_left_reg;
        tdc_left_next = tdc_left_reg;
        cur_tdc_next  = cur_tdc_reg;
        take_hdr      = 1'b0;

        item            = '0;
        item.kind       = KIND_SUBHDR;
        item.word       = in_data.word;

        if (in_data.first_word) begin
            item.size_error = size_over;
            hdr_idx_next    = 2'd1;
            top_left_next   = '0;
            tdc_left_next   = '0;
            sub_left_next   = (size_sat != 16'd0) ? size_sat - 16'd1 : 16'd0;
            mode_next       = (sub_left_next == 16'd0) ? MODE_IDLE : MODE_SUBHDR;
        end else if (mode_reg == MODE_IDLE) begin
            item.kind = KIND_STRAY;
        end else begin
            if (mode_reg == MODE_SUBHDR) begin
                hdr_idx_next = hdr_idx_reg + 2'd1;
                if (hdr_idx_next == 2'd0) begin
                    mode_next = MODE_TOPHDR;
                end
            end else begin
                if (mode_reg == MODE_TOPHDR) begin
                    top_left_next = blk_cnt;
                    take_hdr      = 1'b1;
                end else begin
                    top_left_next = top_left_reg - 16'd1;
                    case (mode_reg)
                        MODE_BLKHDR: begin
                            take_hdr = 1'b1;
                        end
                        MODE_HUBTDC: begin
                            cur_tdc_next  = blk_id;
                            tdc_left_next = blk_cnt;
                            mode_next     = (blk_cnt != 16'd0) ? MODE_DATA : MODE_BLKHDR;
                            item.kind     = KIND_BLKHDR;
                            item.tdc_id   = blk_id;
                        end
                        default: begin
                            item.tdc_id = cur_tdc_reg;
                            if (mode_reg == MODE_SKIP) begin
                                item.kind = KIND_SKIPPED;
                            end else begin
                                item.kind   = KIND_UNKNOWN;
                                item.decode = 1'b1;
                            end
                            tdc_left_next = tdc_left_reg - 16'd1;
                            if (tdc_left_next == 16'd0) begin
                                mode_next = MODE_BLKHDR;
                            end
                        end
                    endcase
                end
                // block header: skip list, hub or tdc block
                if (take_hdr) begin
                    item.kind    = KIND_BLKHDR;
                    item.tdc_id  = blk_id;
                    cur_tdc_next = blk_id;
                    if (is_skip_id(blk_id)) begin
                        tdc_left_next = blk_cnt;
                        mode_next     = (blk_cnt != 16'd0) ? MODE_SKIP : MODE_BLKHDR;
                    end else if (is_hub_id(blk_id)) begin
                        tdc_left_next = '0;
                        mode_next     = MODE_HUBTDC;
                    end else begin
                        tdc_left_next = blk_cnt;
                        mode_next     = (blk_cnt != 16'd0) ? MODE_DATA : MODE_BLKHDR;
                    end
                end
                if (top_left_next == 16'd0) begin
                    mode_next = MODE_TOPHDR;
                end
            end
            sub_left_next = sub_left_reg - 16'd1;
            if (sub_left_next == 16'd0) begin
                mode_next = MODE_IDLE;
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            hdr_idx_reg  <= '0;
            sub_left_reg <= '0;
            top_left_reg <= '0;
            tdc_left_reg <= '0;
            cur_tdc_reg  <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            hdr_idx_reg  <= hdr_idx_next;
            sub_left_reg <= sub_left_next;
            top_left_reg <= top_left_next;
            tdc_left_reg <= tdc_left_next;
            cur_tdc_reg  <= cur_tdc_next;
        end
    end

endmodule

FILE: rtl/tsu_queue.sv
// tsu_queue: small fifo of classified words between parser and decoder
// depends on tsu_pkg
module tsu_queue import tsu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  tsu_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output tsu_item_t pop_item
);

    tsu_item_t entry_reg [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // no push into a full queue unless an entry leaves
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && full) |-> pop)
        else $error("queue overflow");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue underflow");

    // pointers stay the fill count apart
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        QUEUE_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])
        else $error("queue pointers out of step with count");

endmodule

FILE: rtl/tsu_back.sv
// tsu_back: payload decoder with epoch register and result output register
// depends on tsu_pkg
module tsu_back import tsu_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      item_valid,
    input  tsu_item_t item,
    output logic      item_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output tsu_out_t  m_data
);

    logic [27:0] epoch_reg, epoch_next;
    logic        out_valid_reg;
    tsu_out_t    out_reg, out_next;
    logic [6:0]  ch;
    logic [9:0]  fine;

    assign item_pop = item_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign ch       = item.word[28:22];
    assign fine     = item.word[21:12];

    // decode time, epoch, header, debug and unknown words
    always_comb begin
        epoch_next          = epoch_reg;
        out_next            = '0;
        out_next.kind       = item.kind;
        out_next.tdc_id     = item.tdc_id;
        out_next.size_error = item.size_error;
        if (item.decode) begin
            if (item.word[31]) begin
                out_next.kind    = (fine == FINE_FAULTY) ? KIND_FAULTY : KIND_HIT;
                out_next.channel = ch;
                if (ch == 7'd0) begin
                    out_next.channel_class = CLASS_SYNC;
                end else if (ch[0]) begin
                    out_next.channel_class = CLASS_LEADING;
                end else begin
                    out_next.channel_class = CLASS_TRAILING;
                end
                out_next.edge_res = item.word[11];
                out_next.epoch    = epoch_reg;
                out_next.coarse   = item.word[10:0];
                out_next.fine     = fine;
            end else begin
                case (item.word[30:29])
                    WTYPE_TDCHDR: out_next.kind = KIND_TDCHDR;
                    WTYPE_DEBUG:  out_next.kind = KIND_DEBUG;
                    WTYPE_EPOCH: begin
                        out_next.kind  = KIND_EPOCH;
                        epoch_next     = item.word[27:0];
                        out_next.epoch = item.word[27:0];
                    end
                    default:      out_next.kind = KIND_UNKNOWN;
                endcase
            end
        end
    end

    // epoch counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_pop) begin
                epoch_reg     <= epoch_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_pop) begin
            out_reg <= out_next;
        end
    end

    // a stalled result is not overwritten
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !item_pop)
        else $error("result overwritten while stalled");

    // epoch changes only on a decoded epoch word
    a_epoch_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!item_pop || !item.decode || item.word[31]) |=> $stable(epoch_reg))
        else $error("epoch changed outside an epoch word");

    // a result appears only after an item was taken
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(item_pop))
        else $error("result without a decoded item");

endmodule

FILE: rtl/tdc_subevent_unpacker_core.sv
// Top level of the tdc subevent unpacker: parser, queue and decoder.
// Depends on tsu_pkg, tsu_front, tsu_queue and tsu_back.
//
// Takes one 32-bit subevent word per transaction and returns exactly one result per
// word. The parser classifies each word in the cycle it is accepted and writes it to
// a four-entry queue; the decoder splits time, epoch, header and debug words, keeps
// the epoch register across subevents and holds the result in an output register.
// Throughput is one word per clock while s_ready is high; with an empty queue each word
// is registered in a queue entry and then in the output register before m_valid rises.
// s_ready drops only when the queue is full, which takes four words waiting behind a
// stalled result. The epoch register is cleared by reset alone; the block counters are
// also cleared on each first word. There is no clearing pass.
module tdc_subevent_unpacker_core import tsu_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tsu_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output tsu_out_t m_data
);

    logic      accept;
    logic      queue_full;
    logic      queue_not_empty;
    logic      queue_pop;
    tsu_item_t front_item;
    tsu_item_t back_item;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // parser
    tsu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_data),
        .item    (front_item)
    );

    // queue between the two halves
    tsu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_item  (back_item)
    );

    // decoder and result register
    tsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_not_empty),
        .item       (back_item),
        .item_pop   (queue_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: dv/tb.sv
// tb: self-checking testbench for tdc_subevent_unpacker_core, one word in and one result out
// depends on tsu_pkg and the unpacker rtl; keeps its own model of the parser and decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsu_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int ITEMS_TARGET = 500;
    localparam logic [1:0] WTYPE_UNKNOWN = 2'd0;

    // parser states of the model
    typedef enum logic [2:0] {
        PS_IDLE, PS_SUBHDR, PS_TOPHDR, PS_BLKHDR, PS_HUBTDC, PS_SKIP, PS_DATA
    } parse_state_e;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tsu_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tsu_out_t m_data;

    // model state, set once at the start like the reset
    parse_state_e ps = PS_IDLE;
    logic [1:0]   hdr_cnt = '0;
    logic [15:0]  sub_left = '0;
    logic [15:0]  top_left = '0;
    logic [15:0]  blk_left = '0;
    logic [15:0]  cur_id = '0;
    logic [27:0]  epoch_reg = '0;

    tsu_out_t     pending_q[$];
    logic [31:0]  frame_q[$];
    int           err_cnt = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    int           hold_req = 0;
    int           cycle_cnt = 0;
    bit           no_gaps = 1'b0;

    tdc_subevent_unpacker_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit skip_id(input logic [15:0] id);
        return id inside {16'h7005, 16'h5555, 16'h0112, 16'hc000};
    endfunction

    function automatic bit hub_id(input logic [15:0] id);
        return id inside {16'h7000, 16'h7001, 16'h7002, 16'h7003};
    endfunction

    // block header: load counters and pick what follows
    function automatic logic [15:0] open_block(input logic [31:0] w);
        cur_id = w[15:0];
        blk_left = w[31:16];
        if (hub_id(w[15:0])) begin
            blk_left = '0;
            ps = PS_HUBTDC;
        end else if (w[31:16] == 16'd0) begin
            ps = PS_BLKHDR;
        end else begin
            ps = skip_id(w[15:0]) ? PS_SKIP : PS_DATA;
        end
        return w[15:0];
    endfunction

    // expected result of one accepted word, advances the model state
    function automatic tsu_out_t unpack_word(input tsu_in_t t);
        tsu_out_t    r;
        logic [29:0] nwords;
        r = '0;
        if (t.first_word) begin
            nwords = t.word[31:2];
            if (nwords > 30'hffff) begin
                nwords = 30'hffff;
                r.size_error = 1'b1;
            end
            r.kind = KIND_SUBHDR;
            hdr_cnt = 2'd1;
            top_left = '0;
            blk_left = '0;
            sub_left = (nwords == 30'd0) ? 16'd0 : 16'(nwords - 30'd1);
            ps = (sub_left == 16'd0) ? PS_IDLE : PS_SUBHDR;
        end else if (ps == PS_IDLE) begin
            r.kind = KIND_STRAY;
        end else begin
            if (ps == PS_SUBHDR) begin
                r.kind = KIND_SUBHDR;
                hdr_cnt++;
                if (hdr_cnt == 2'd0)
                    ps = PS_TOPHDR;
            end else begin
                if (ps == PS_TOPHDR) begin
                    top_left = t.word[31:16];
                    r.kind = KIND_BLKHDR;
                    r.tdc_id = open_block(t.word);
                end else begin
                    top_left--;
                    if (ps == PS_BLKHDR) begin
                        r.kind = KIND_BLKHDR;
                        r.tdc_id = open_block(t.word);
                    end else if (ps == PS_HUBTDC) begin
                        cur_id = t.word[15:0];
                        blk_left = t.word[31:16];
                        ps = (blk_left == 16'd0) ? PS_BLKHDR : PS_DATA;
                        r.kind = KIND_BLKHDR;
                        r.tdc_id = cur_id;
                    end else begin
                        r.tdc_id = cur_id;
                        if (ps == PS_SKIP) begin
                            r.kind = KIND_SKIPPED;
                        end else if (t.word[31]) begin
                            // time word
                            r.channel = t.word[28:22];
                            r.fine = t.word[21:12];
                            r.edge_res = t.word[11];
                            r.coarse = t.word[10:0];
                            r.epoch = epoch_reg;
                            r.channel_class = (r.channel == 7'd0) ? CLASS_SYNC :
                                              (r.channel[0] ? CLASS_LEADING : CLASS_TRAILING);
                            r.kind = (r.fine == FINE_FAULTY) ? KIND_FAULTY : KIND_HIT;
                        end else begin
                            case (t.word[30:29])
                                WTYPE_TDCHDR: r.kind = KIND_TDCHDR;
                                WTYPE_DEBUG:  r.kind = KIND_DEBUG;
                                WTYPE_EPOCH: begin
                                    epoch_reg = t.word[27:0];
                                    r.epoch = epoch_reg;
                                    r.kind = KIND_EPOCH;
                                end
                                default: r.kind = KIND_UNKNOWN;
                            endcase
                        end
                        blk_left--;
                        if (blk_left == 16'd0)
                            ps = PS_BLKHDR;
                    end
                end
                if (top_left == 16'd0)
                    ps = PS_TOPHDR;
            end
            sub_left--;
            if (sub_left == 16'd0)
                ps = PS_IDLE;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_cnt < 100)
            $display("mismatch at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic compare_result(input tsu_out_t got, input tsu_out_t want);
        check_field("kind", 32'(got.kind), 32'(want.kind));
        check_field("tdc_id", 32'(got.tdc_id), 32'(want.tdc_id));
        check_field("channel", 32'(got.channel), 32'(want.channel));
        check_field("channel_class", 32'(got.channel_class), 32'(want.channel_class));
        check_field("edge_res", 32'(got.edge_res), 32'(want.edge_res));
        check_field("epoch", 32'(got.epoch), 32'(want.epoch));
        check_field("coarse", 32'(got.coarse), 32'(want.coarse));
        check_field("fine", 32'(got.fine), 32'(want.fine));
        check_field("size_error", 32'(got.size_error), 32'(want.size_error));
    endtask

    // watch both channels: predict on each input transaction, check each result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0)
                    report_mismatch("result with no pending word");
                else
                    compare_result(m_data, pending_q.pop_front());
            end
            if (s_valid && s_ready)
                pending_q.push_back(unpack_word(s_data));
        end
    end

    // receiver: ready on a changing duty pattern, or a long hold when asked
    initial begin
        int n;
        int ready_pct;
        int left;
        ready_pct = 100;
        left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                n = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    ready_pct = 25 * $urandom_range(1, 4);
                    left = $urandom_range(20, 80);
                end
                left--;
                m_ready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // one input transaction, then maybe a gap between bursts
    task automatic send_word(input logic [31:0] w, input logic first);
        s_valid <= 1'b1;
        s_data <= '{word: w, first_word: first};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 8);
            end
        end
    endtask

    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++)
            send_word(frame_q[i], i == 0);
    endtask

    // stop offering and wait until every result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_q.size() != 0);
    endtask

    function automatic logic [15:0] rand_data_id();
        logic [15:0] id;
        do id = 16'($urandom); while (skip_id(id) || hub_id(id));
        return id;
    endfunction

    function automatic logic [15:0] rand_skip_id();
        logic [15:0] id;
        case ($urandom_range(0, 3))
            0: id = 16'h7005;
            1: id = 16'h5555;
            2: id = 16'h0112;
            default: id = 16'hc000;
        endcase
        return id;
    endfunction

    // random tdc payload word, all word types
    function automatic logic [31:0] rand_payload();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w[31] = 1'b1;
            4: begin
                w[31] = 1'b1;
                w[21:12] = FINE_FAULTY;
            end
            5: begin
                w[31] = 1'b1;
                w[28:22] = $urandom_range(0, 1) ? 7'd0 : 7'h7f;
            end
            6: w[31:29] = {1'b0, WTYPE_EPOCH};
            7: w[31:29] = {1'b0, WTYPE_TDCHDR};
            8: w[31:29] = {1'b0, WTYPE_DEBUG};
            default: w[31:29] = {1'b0, WTYPE_UNKNOWN};
        endcase
        return w;
    endfunction

    // well-formed subevent in frame_q; short_hub makes a hub count cut its inner blocks
    task automatic build_subevent(input int n_blocks, input int max_len, input bit short_hub);
        logic [31:0] inner_q[$];
        int          len;
        int          sel;
        frame_q = {};
        frame_q.push_back(32'h0);
        repeat (3) frame_q.push_back($urandom);
        repeat (n_blocks) begin
            sel = $urandom_range(0, 9);
            len = $urandom_range(0, max_len);
            if (sel < 5) begin
                frame_q.push_back({16'(len), rand_data_id()});
                repeat (len) frame_q.push_back(rand_payload());
            end else if (sel < 7) begin
                frame_q.push_back({16'(len), rand_skip_id()});
                repeat (len) frame_q.push_back($urandom);
            end else begin
                // hub with one or two tdc blocks inside
                inner_q = {};
                repeat ($urandom_range(1, 2)) begin
                    inner_q.push_back({16'(len), rand_data_id()});
                    repeat (len) inner_q.push_back(rand_payload());
                    len = $urandom_range(0, max_len);
                end
                len = short_hub ? $urandom_range(1, inner_q.size()) : inner_q.size();
                frame_q.push_back({16'(len), 16'h7000 + 16'($urandom_range(0, 3))});
                foreach (inner_q[i]) frame_q.push_back(inner_q[i]);
            end
        end
        frame_q[0] = frame_q.size() * 4 + $urandom_range(0, 3);
    endtask

    // stray word, tiny sizes, oversized size, flag inside an open subevent
    task automatic test_corner_words();
        send_word(32'hffff_ffff, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hffff_ffff, 1'b1);
        send_word(32'h0000_0003, 1'b1);
        wait_drained();
    endtask

    // every payload kind, hub overrun, inner block shorter than its hub, skip, zero count
    task automatic test_payload_kinds();
        frame_q = {
            32'd90, 32'hffff_ffff, 32'h0000_0000, 32'ha5a5_a5a5,
            32'h0006_1234,
            32'h8000_5003,   // hit on sync channel
            32'h9fc0_0fff,   // channel 127, edge set, coarse max
            32'he0bf_f123,   // faulty hit on channel 2
            32'h6fff_ffff,   // epoch all ones
            32'h807f_e8aa,   // hit carrying the new epoch
            32'h2abc_def0,   // tdc header
            32'h0002_7001,   // hub whose count is too short
            32'h0003_0055,
            32'h5000_0001,   // debug, then hub count runs out
            32'h0004_7000,   // hub with two inner blocks
            32'h0001_0101,
            32'h1fff_ffff,   // unknown
            32'h0001_0102,
            32'h6000_0000,   // epoch zero
            32'h0001_c000,   // skipped block
            32'hffff_ffff,
            32'h0000_0042    // zero count block
        };
        send_frame(frame_q.size());
        wait_drained();
    endtask

    // receiver holds off long while the sender keeps offering words
    task automatic test_backpressure();
        do build_subevent(4, 6, 1'b0); while (frame_q.size() < 16);
        hold_req = 64;
        no_gaps = 1'b1;
        send_frame(frame_q.size());
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // mostly well-formed subevents, some broken ones and noise
    task automatic test_random_traffic();
        int v;
        int n;
        while (items_sent < ITEMS_TARGET) begin
            v = $urandom_range(0, 19);
            build_subevent($urandom_range(1, 4), ($urandom_range(0, 7) == 0) ? 20 : 6, v == 15);
            n = frame_q.size();
            case (v)
                12: wait_drained();
                14: n = $urandom_range(1, frame_q.size());
                16: frame_q[0] = $urandom_range(0, frame_q.size() * 4);
                17: frame_q[0] = $urandom;
                18: frame_q[$urandom_range(1, frame_q.size() - 1)] = $urandom;
                default: ;
            endcase
            if (v == 19)
                repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0);
            else
                send_frame(n);
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_corner_words();
        test_payload_kinds();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (16) @(negedge aclk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
